[hw/rtl/prgcrc_pkg.sv]
// Package for the programmable CRC unit: field widths, register indexes,
// size and width codes, and the configuration bundle. No dependencies.
package prgcrc_pkg;

  localparam int unsigned CrcW   = 32;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DataBitsW = 6;

  localparam logic [CrcW-1:0] PolyReset = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] InitReset = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] CrcReset  = 32'hFFFF_FFFF;

  typedef enum logic {
    ACT_FEED   = 1'b0,
    ACT_RELOAD = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    SIZE_32 = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_8  = 2'd2,
    SIZE_7  = 2'd3
  } poly_size_e;

  typedef enum logic [1:0] {
    DW_8      = 2'd0,
    DW_16     = 2'd1,
    DW_32     = 2'd2,
    DW_32_ALT = 2'd3
  } data_width_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLY = 2'd0,
    REG_INIT = 2'd1,
    REG_SIZE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    poly_size_e      size;
  } cfg_t;

  // Left shift that puts a CRC of the given size at the top of the word.
  function automatic logic [ShiftW-1:0] size_shift(poly_size_e size);
    logic [ShiftW-1:0] sh;
    unique case (size)
      SIZE_32: sh = 5'd0;
      SIZE_16: sh = 5'd16;
      SIZE_8:  sh = 5'd24;
      SIZE_7:  sh = 5'd25;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

[hw/rtl/prgcrc_core.sv]
// Next-CRC logic: absorbs one data word MSB first or reloads the init value.
// Depends on prgcrc_pkg. Purely combinational.
module prgcrc_core (
  input  prgcrc_pkg::cfg_t        cfg_i,
  input  logic [31:0]             crc_i,
  input  logic                    action_i,
  input  logic [31:0]             data_word_i,
  input  logic [1:0]              data_width_i,
  output logic [31:0]             crc_o
);
  import prgcrc_pkg::*;

  logic [ShiftW-1:0]    sh;
  logic [CrcW-1:0]      mask;
  logic [CrcW-1:0]      crc_al;
  logic [CrcW-1:0]      poly_al;
  logic [CrcW-1:0]      data_al;
  logic [DataBitsW-1:0] data_bits;
  logic [CrcW-1:0]      crc_fed;

  assign sh      = size_shift(cfg_i.size);
  assign mask    = {CrcW{1'b1}} >> sh;
  // Work with the CRC left-aligned so the feedback tap is always bit 31;
  // bits above the current size fall off here.
  assign crc_al  = crc_i << sh;
  assign poly_al = cfg_i.poly << sh;

  always_comb begin
    unique case (data_width_e'(data_width_i))
      DW_8: begin
        data_al   = data_word_i << 24;
        data_bits = 6'd8;
      end
      DW_16: begin
        data_al   = data_word_i << 16;
        data_bits = 6'd16;
      end
      DW_32, DW_32_ALT: begin
        data_al   = data_word_i;
        data_bits = 6'd32;
      end
      default: begin
        data_al   = data_word_i;
        data_bits = 6'd32;
      end
    endcase
  end

  // Unrolled bit-serial division, one XOR stage per data bit.
  always_comb begin
    logic [CrcW-1:0] c;
    logic            fb;
    c  = crc_al;
    fb = 1'b0;
    for (int k = 0; k < CrcW; k++) begin
      if (DataBitsW'(k) < data_bits) begin
        fb = c[CrcW-1] ^ data_al[CrcW-1-k];
        c  = {c[CrcW-2:0], 1'b0} ^ (fb ? poly_al : '0);
      end
    end
    crc_fed = c >> sh;
  end

  always_comb begin
    unique case (action_e'(action_i))
      ACT_RELOAD: crc_o = cfg_i.init & mask;
      ACT_FEED:   crc_o = crc_fed;
      default:    crc_o = crc_fed;
    endcase
  end

endmodule

[hw/rtl/programmable_crc_unit.sv]
// Top level of the programmable CRC unit: config registers, input stage,
// running CRC and result register. Depends on prgcrc_pkg and prgcrc_core.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_stall_o  action, data_word, data_width, eob
//   output    out        out_valid_o/out_stall_i crc_value, block_done
//   config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while the output is not stalled; an accepted
// word waits in the input stage and its CRC lands in the result register.
// The running CRC updates as a word leaves the input stage, so each word
// sees the CRC left by the one before it without a bubble.
// Asynchronous active-low reset clears valids, loads default registers.
// A stalled output holds its result; the input stalls only when both stages
// are full and the output is stalled.
module programmable_crc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] data_word_i,
  input  logic [1:0]  data_width_i,
  input  logic        end_of_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_value_o,
  output logic        block_done_o
);
  import prgcrc_pkg::*;

  cfg_t            cfg_q;
  logic [CrcW-1:0] crc_q;
  logic [CrcW-1:0] crc_d;

  logic            s1_vld_q;
  logic            s1_action_q;
  logic [CrcW-1:0] s1_data_q;
  logic [1:0]      s1_width_q;
  logic            s1_eob_q;

  logic            out_vld_q;
  logic [CrcW-1:0] out_crc_q;
  logic            out_eob_q;

  logic            in_acc;
  logic            advance;

  assign advance    = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly <= PolyReset;
      cfg_q.init <= InitReset;
      cfg_q.size <= SIZE_32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLY: cfg_q.poly <= cfg_wdata_i;
        REG_INIT: cfg_q.init <= cfg_wdata_i;
        REG_SIZE: cfg_q.size <= poly_size_e'(cfg_wdata_i[1:0]);
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  prgcrc_core u_core (
    .cfg_i        (cfg_q),
    .crc_i        (crc_q),
    .action_i     (s1_action_q),
    .data_word_i  (s1_data_q),
    .data_width_i (s1_width_q),
    .crc_o        (crc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      crc_q     <= CrcReset;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        crc_q     <= crc_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_action_q <= action_i;
      s1_data_q   <= data_word_i;
      s1_width_q  <= data_width_i;
      s1_eob_q    <= end_of_block_i;
    end
    if (advance) begin
      out_crc_q <= crc_d;
      out_eob_q <= s1_eob_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign crc_value_o  = out_crc_q;
  assign block_done_o = out_eob_q;

endmodule

[hw/rtl/prgcrc_checker.sv]
// Port-level checker for the programmable CRC unit, bound to the top level.
// Depends on prgcrc_pkg; tracks the size register from the config port.
module prgcrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [31:0] cfg_wdata_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] crc_value_o,
  input logic        block_done_o
);
  import prgcrc_pkg::*;

  logic [1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_32;
    end else if (cfg_we_i && cfg_idx_i == REG_SIZE) begin
      size_q <= cfg_wdata_i[1:0];
    end
  end

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(crc_value_o)
      && $stable(block_done_o))
    else $error("stalled result changed");

  // The input side only backs up behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output could drain");

  // Result bits above the CRC size are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_q == SIZE_16 |-> crc_value_o[31:16] == 16'd0)
    else $error("16-bit CRC has high bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (size_q == SIZE_8 || size_q == SIZE_7) |-> crc_value_o[31:8] == 24'd0
      && (size_q == SIZE_8 || !crc_value_o[7]))
    else $error("narrow CRC has high bits set");

endmodule

bind programmable_crc_unit prgcrc_checker u_prgcrc_checker (.*);
